>>> rtl/mie_pkg.sv
`default_nettype none
package mie_pkg;

  localparam int unsigned MEM_BYTES_DEFAULT = 1024;

  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0A;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_ORI   = 6'h0D;
  localparam logic [5:0] OP_NORI  = 6'h0E;
  localparam logic [5:0] OP_LUI   = 6'h0F;
  localparam logic [5:0] OP_LB    = 6'h20;
  localparam logic [5:0] OP_LH    = 6'h21;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_LBU   = 6'h24;
  localparam logic [5:0] OP_LHU   = 6'h25;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2B;

  typedef enum logic [4:0] {
    K_ADDI, K_ADDIU, K_ANDI, K_ORI, K_NORI, K_SLTI, K_LUI, K_BEQ, K_BNE,
    K_LB, K_LH, K_LW, K_LBU, K_LHU, K_SB, K_SH, K_SW, K_BAD
  } kind_e;

  typedef struct packed {
    logic [5:0]         opcode;
    logic [4:0]         src_reg;
    logic [4:0]         tgt_reg;
    logic signed [15:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        branch_taken;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        mem_written;
    logic [9:0]  mem_byte_addr;
    logic        bad_opcode;
  } out_item_t;

  // decoded instruction held in the queue
  typedef struct packed {
    kind_e       kind;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [15:0] imm;
  } dec_t;

  typedef struct packed {
    logic pop;
    logic init;
  } back_ctrl_t;

  function automatic kind_e decode(input logic [5:0] op);
    kind_e k;
    case (op)
      OP_BEQ:   k = K_BEQ;
      OP_BNE:   k = K_BNE;
      OP_ADDI:  k = K_ADDI;
      OP_ADDIU: k = K_ADDIU;
      OP_SLTI:  k = K_SLTI;
      OP_ANDI:  k = K_ANDI;
      OP_ORI:   k = K_ORI;
      OP_NORI:  k = K_NORI;
      OP_LUI:   k = K_LUI;
      OP_LB:    k = K_LB;
      OP_LH:    k = K_LH;
      OP_LW:    k = K_LW;
      OP_LBU:   k = K_LBU;
      OP_LHU:   k = K_LHU;
      OP_SB:    k = K_SB;
      OP_SH:    k = K_SH;
      OP_SW:    k = K_SW;
      default:  k = K_BAD;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

>>> rtl/mie_if.sv
`default_nettype none
interface mie_in_if;
  logic               valid;
  logic               ready;
  mie_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mie_out_if;
  logic               valid;
  logic               ready;
  mie_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/mie_front.sv
`default_nettype none
module mie_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  mie_in_if.sink               in_i,
  input  mie_pkg::back_ctrl_t  ctrl_i,
  output logic                 head_valid_o,
  output mie_pkg::dec_t        head_o
);

  mie_pkg::dec_t fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_i.ready   = !ctrl_i.init && (cnt_q != 2'd2);
  assign push         = in_i.valid && in_i.ready;
  assign pop          = ctrl_i.pop && (cnt_q != 2'd0);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q].kind <= mie_pkg::decode(in_i.data.opcode);
      fifo_q[wr_ptr_q].rs   <= in_i.data.src_reg;
      fifo_q[wr_ptr_q].rt   <= in_i.data.tgt_reg;
      fifo_q[wr_ptr_q].imm  <= in_i.data.immediate;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule
`default_nettype wire

>>> rtl/mie_back.sv
`default_nettype none
module mie_back #(
  parameter int unsigned MemBytes = mie_pkg::MEM_BYTES_DEFAULT
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  head_valid_i,
  input  mie_pkg::dec_t        head_i,
  output mie_pkg::back_ctrl_t  ctrl_o,
  mie_out_if.source            out_o
);

  localparam int unsigned AddrW = $clog2(MemBytes);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_ISSUE, ST_EXEC, ST_LDA, ST_LDD, ST_STORE, ST_DONE
  } state_e;

  state_e state_q;

  logic [7:0]  dmem [MemBytes];
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_q;

  logic [AddrW-1:0] clr_q;
  mie_pkg::dec_t    ins_q;
  logic [31:0]      a_q, b_q;
  logic             a_vld_q, b_vld_q;
  logic [31:0]      pc_q, npc_q, val_q, sd_q, acc_q;
  logic [AddrW-1:0] ea_q;
  logic [1:0]       k_q, last_q;
  logic             wr_q, taken_q, mem_q, uses_q, bad_q;
  logic [7:0]       rdata_q;

  mie_pkg::out_item_t out_q;
  logic               out_valid_q;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata;
  logic             rf_we;
  logic [31:0]      a, b, simm, zimm, sum, ea32, pc4, fin_val;
  logic             can_out, wr_fin;

  // execute-stage results
  logic [31:0] x_npc, x_val, x_sd;
  logic [1:0]  x_last;
  logic        x_wr, x_taken, x_mem, x_uses, x_bad;
  state_e      x_state;

  assign a     = a_vld_q ? a_q : 32'd0;
  assign b     = b_vld_q ? b_q : 32'd0;
  assign simm  = {{16{ins_q.imm[15]}}, ins_q.imm};
  assign zimm  = {16'd0, ins_q.imm};
  assign sum   = a + simm;
  assign ea32  = sum & (32'(MemBytes) - 32'd1);
  assign pc4   = pc_q + 32'd4;

  assign can_out = !out_valid_q || out_o.ready;
  assign wr_fin  = wr_q && (ins_q.rt != 5'd0);
  assign rf_we   = (state_q == ST_DONE) && can_out && wr_fin;

  always_comb begin
    x_npc   = pc4;
    x_val   = 32'd0;
    x_sd    = b;
    x_last  = 2'd0;
    x_wr    = 1'b0;
    x_taken = 1'b0;
    x_mem   = 1'b0;
    x_uses  = 1'b0;
    x_bad   = 1'b0;
    x_state = ST_DONE;
    case (ins_q.kind)
      mie_pkg::K_ADDI:  begin x_val = sum;          x_wr = 1'b1; end
      mie_pkg::K_ADDIU: begin x_val = a + zimm;     x_wr = 1'b1; end
      mie_pkg::K_ANDI:  begin x_val = a & zimm;     x_wr = 1'b1; end
      mie_pkg::K_ORI:   begin x_val = a | zimm;     x_wr = 1'b1; end
      mie_pkg::K_NORI:  begin x_val = ~(a | zimm);  x_wr = 1'b1; end
      mie_pkg::K_SLTI: begin
        x_val = {31'd0, $signed(a) < $signed(simm)};
        x_wr  = 1'b1;
      end
      mie_pkg::K_LUI:   begin x_val = {ins_q.imm, 16'd0}; x_wr = 1'b1; end
      mie_pkg::K_BEQ, mie_pkg::K_BNE: begin
        if ((a == b) == (ins_q.kind == mie_pkg::K_BEQ)) begin
          x_taken = 1'b1;
          x_npc   = pc4 + {simm[29:0], 2'b00};
        end
      end
      mie_pkg::K_LW, mie_pkg::K_LH, mie_pkg::K_LHU, mie_pkg::K_LB,
      mie_pkg::K_LBU: begin
        x_wr    = 1'b1;
        x_uses  = 1'b1;
        x_last  = (ins_q.kind == mie_pkg::K_LW) ? 2'd3 :
                  (ins_q.kind == mie_pkg::K_LH ||
                   ins_q.kind == mie_pkg::K_LHU) ? 2'd1 : 2'd0;
        x_state = ST_LDA;
      end
      mie_pkg::K_SW, mie_pkg::K_SH, mie_pkg::K_SB: begin
        x_mem  = 1'b1;
        x_uses = 1'b1;
        // left-align the bytes to store, MSB goes first
        if (ins_q.kind == mie_pkg::K_SW) begin
          x_last = 2'd3;
        end else if (ins_q.kind == mie_pkg::K_SH) begin
          x_last = 2'd1;
          x_sd   = {b[15:0], 16'd0};
        end else begin
          x_last = 2'd0;
          x_sd   = {b[7:0], 24'd0};
        end
        x_state = ST_STORE;
      end
      default: begin
        x_bad = 1'b1;
        x_npc = pc_q;
      end
    endcase
  end

  always_comb begin
    case (ins_q.kind)
      mie_pkg::K_LW:  fin_val = acc_q;
      mie_pkg::K_LH:  fin_val = {{16{acc_q[15]}}, acc_q[15:0]};
      mie_pkg::K_LHU: fin_val = {16'd0, acc_q[15:0]};
      mie_pkg::K_LB:  fin_val = {{24{acc_q[7]}}, acc_q[7:0]};
      mie_pkg::K_LBU: fin_val = {24'd0, acc_q[7:0]};
      default:        fin_val = val_q;
    endcase
  end

  assign mem_raddr = ea_q + AddrW'(k_q);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = 8'd0;
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_q == ST_STORE) begin
      mem_we    = 1'b1;
      mem_waddr = mem_raddr;
      mem_wdata = sd_q[31:24];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) dmem[mem_waddr] <= mem_wdata;
    rdata_q <= dmem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[ins_q.rt] <= fin_val;
    a_q <= rf_mem[head_i.rs];
    b_q <= rf_mem[head_i.rt];
  end

  assign ctrl_o.pop  = (state_q == ST_ISSUE) && head_valid_i;
  assign ctrl_o.init = (state_q == ST_CLEAR);

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rf_vld_q    <= '0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != ST_DONE)) out_valid_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AddrW'(1);
          if (clr_q == AddrW'(MemBytes - 1)) state_q <= ST_ISSUE;
        end
        ST_ISSUE: begin
          if (head_valid_i) begin
            ins_q   <= head_i;
            a_vld_q <= rf_vld_q[head_i.rs];
            b_vld_q <= rf_vld_q[head_i.rt];
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          npc_q   <= x_npc;
          val_q   <= x_val;
          wr_q    <= x_wr;
          taken_q <= x_taken;
          mem_q   <= x_mem;
          uses_q  <= x_uses;
          bad_q   <= x_bad;
          ea_q    <= AddrW'(ea32);
          k_q     <= 2'd0;
          last_q  <= x_last;
          sd_q    <= x_sd;
          acc_q   <= 32'd0;
          state_q <= x_state;
        end
        ST_LDA: state_q <= ST_LDD;
        ST_LDD: begin
          acc_q <= {acc_q[23:0], rdata_q};
          k_q   <= k_q + 2'd1;
          state_q <= (k_q == last_q) ? ST_DONE : ST_LDA;
        end
        ST_STORE: begin
          sd_q  <= {sd_q[23:0], 8'd0};
          k_q   <= k_q + 2'd1;
          if (k_q == last_q) state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (can_out) begin
            out_valid_q         <= 1'b1;
            out_q.next_pc       <= npc_q;
            out_q.branch_taken  <= taken_q;
            out_q.reg_written   <= wr_fin;
            out_q.dest_index    <= wr_fin ? ins_q.rt : 5'd0;
            out_q.dest_value    <= wr_fin ? fin_val : 32'd0;
            out_q.mem_written   <= mem_q;
            out_q.mem_byte_addr <= uses_q ? 10'(32'(ea_q)) : 10'd0;
            out_q.bad_opcode    <= bad_q;
            if (wr_fin) rf_vld_q[ins_q.rt] <= 1'b1;
            pc_q    <= npc_q;
            state_q <= ST_ISSUE;
          end
        end
        default: state_q <= ST_ISSUE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/mips_itype_execute_unit.sv
`default_nettype none
// MIPS I-type execute unit. A front end decodes instructions into a two-deep
// queue; the back end executes them against a 32x32 register file, the pc
// and a MEM_BYTES byte data memory (power of two, addresses wrap). Every
// instruction passes the issue, execute and done states; loads add a read-address
// and a read-data state for each byte, stores a store state for each byte.
// Register-file reads are registered. After reset the data memory is cleared
// byte by byte, during which no instruction is accepted. Unknown opcodes change
// nothing and flag bad_opcode.
module mips_itype_execute_unit #(
  parameter int unsigned MEM_BYTES = mie_pkg::MEM_BYTES_DEFAULT
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  mie_in_if.sink      in_i,
  mie_out_if.source   out_o
);

  mie_pkg::back_ctrl_t ctrl;
  mie_pkg::dec_t       head;
  logic                head_valid;

  mie_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .ctrl_i       (ctrl),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  mie_back #(.MemBytes(MEM_BYTES)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .ctrl_o       (ctrl),
    .out_o        (out_o)
  );

endmodule
`default_nettype wire

>>> sim/mips_itype_execute_unit_checker.sv
module mips_itype_execute_unit_checker (
  input  wire        clk_i,
  input  wire        rst_ni,
  mie_in_if.sink     in_i,
  mie_out_if.sink    out_i,
  output int         errors_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MEM_BYTES = mie_pkg::MEM_BYTES_DEFAULT;
  localparam int unsigned AW = $clog2(MEM_BYTES);

  logic [31:0]         regs [32];
  logic [31:0]         pc;
  logic [7:0]          dmem [MEM_BYTES];
  mie_pkg::out_item_t  expected_q [$];
  int                  errors;

  assign errors_o  = errors;
  assign pending_o = expected_q.size();

  function automatic logic [AW-1:0] wrap(logic [31:0] ea, int unsigned off);
    return AW'((ea + off) % MEM_BYTES);
  endfunction

  function automatic logic [7:0] mem_rd(logic [31:0] ea, int unsigned off);
    return dmem[wrap(ea, off)];
  endfunction

  task automatic execute(input mie_pkg::in_item_t it);
    mie_pkg::out_item_t r;
    logic [31:0] a, b, simm, zimm, ea, val;
    logic        wr, st, mem, taken, bad;
    a = regs[it.src_reg];
    b = regs[it.tgt_reg];
    zimm = {16'h0, it.immediate};
    simm = {{16{it.immediate[15]}}, it.immediate};
    ea = (a + simm) % MEM_BYTES;
    val = '0; wr = 1'b0; st = 1'b0; mem = 1'b0; taken = 1'b0; bad = 1'b0;
    case (it.opcode)
      mie_pkg::OP_ADDI:  begin val = a + simm; wr = 1'b1; end
      mie_pkg::OP_ADDIU: begin val = a + zimm; wr = 1'b1; end
      mie_pkg::OP_ANDI:  begin val = a & zimm; wr = 1'b1; end
      mie_pkg::OP_ORI:   begin val = a | zimm; wr = 1'b1; end
      mie_pkg::OP_NORI:  begin val = ~(a | zimm); wr = 1'b1; end
      mie_pkg::OP_SLTI: begin
        val = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0; wr = 1'b1;
      end
      mie_pkg::OP_LUI:   begin val = zimm << 16; wr = 1'b1; end
      mie_pkg::OP_BEQ:   taken = (a == b);
      mie_pkg::OP_BNE:   taken = (a != b);
      mie_pkg::OP_LW: begin
        val = {mem_rd(ea, 0), mem_rd(ea, 1), mem_rd(ea, 2), mem_rd(ea, 3)};
        wr = 1'b1; mem = 1'b1;
      end
      mie_pkg::OP_LH: begin
        val[15:0] = {mem_rd(ea, 0), mem_rd(ea, 1)};
        val = {{16{val[15]}}, val[15:0]}; wr = 1'b1; mem = 1'b1;
      end
      mie_pkg::OP_LHU: begin
        val = {16'h0, mem_rd(ea, 0), mem_rd(ea, 1)}; wr = 1'b1; mem = 1'b1;
      end
      mie_pkg::OP_LB: begin
        val[7:0] = mem_rd(ea, 0);
        val = {{24{val[7]}}, val[7:0]}; wr = 1'b1; mem = 1'b1;
      end
      mie_pkg::OP_LBU: begin val = {24'h0, mem_rd(ea, 0)}; wr = 1'b1; mem = 1'b1; end
      mie_pkg::OP_SW: begin
        dmem[wrap(ea, 0)] = b[31:24]; dmem[wrap(ea, 1)] = b[23:16];
        dmem[wrap(ea, 2)] = b[15:8];  dmem[wrap(ea, 3)] = b[7:0];
        st = 1'b1; mem = 1'b1;
      end
      mie_pkg::OP_SH: begin
        dmem[wrap(ea, 0)] = b[15:8]; dmem[wrap(ea, 1)] = b[7:0];
        st = 1'b1; mem = 1'b1;
      end
      mie_pkg::OP_SB: begin dmem[wrap(ea, 0)] = b[7:0]; st = 1'b1; mem = 1'b1; end
      default: bad = 1'b1;
    endcase
    if (it.tgt_reg == 5'd0) wr = 1'b0;
    if (wr) regs[it.tgt_reg] = val;
    r = '0;
    r.next_pc = bad ? pc : (taken ? pc + 32'd4 + (simm << 2) : pc + 32'd4);
    pc = r.next_pc;
    r.branch_taken = taken;
    r.reg_written = wr;
    r.dest_index = wr ? it.tgt_reg : 5'd0;
    r.dest_value = wr ? val : 32'd0;
    r.mem_written = st;
    r.mem_byte_addr = mem ? ea[9:0] : 10'd0;
    r.bad_opcode = bad;
    expected_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mie_pkg::out_item_t e;
    if (!rst_ni) begin
      foreach (regs[i]) regs[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      pc = '0;
      expected_q.delete();
      errors = 0;
    end else begin
      if (in_i.valid && in_i.ready) execute(in_i.data);
      if (out_i.valid && out_i.ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %p", out_i.data);
        end else begin
          e = expected_q.pop_front();
          if (out_i.data !== e) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", e, out_i.data);
          end
        end
      end
    end
  end
endmodule

>>> sim/mips_itype_execute_unit_test.sv
module mips_itype_execute_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors, pending, cycles;
  bit   quiet, hold_sink, hold_go;

  mie_in_if  in_ch ();
  mie_out_if out_ch ();

  mips_itype_execute_unit i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  mips_itype_execute_unit_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_i(out_ch.sink),
    .errors_o(errors), .pending_o(pending)
  );

  always #1 clk_i = ~clk_i;

  localparam logic [5:0] OPS [17] = '{mie_pkg::OP_ADDI, mie_pkg::OP_ADDIU,
    mie_pkg::OP_ANDI, mie_pkg::OP_ORI, mie_pkg::OP_NORI, mie_pkg::OP_SLTI,
    mie_pkg::OP_LUI, mie_pkg::OP_BEQ, mie_pkg::OP_BNE, mie_pkg::OP_LB,
    mie_pkg::OP_LH, mie_pkg::OP_LW, mie_pkg::OP_LBU, mie_pkg::OP_LHU,
    mie_pkg::OP_SB, mie_pkg::OP_SH, mie_pkg::OP_SW};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // sink side: random stalls, or a full hold-off while hold_sink is set
  always @(posedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= !hold_sink && (quiet || $urandom_range(99) >= 8);
  end

  // long hold-off while the sender keeps offering beats
  initial begin
    wait (hold_go);
    hold_sink = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_sink = 1'b0;
  end

  task automatic send(input logic [5:0] op, input logic [4:0] rs, input logic [4:0] rt,
                      input logic [15:0] imm);
    while (!quiet && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{opcode: op, src_reg: rs, tgt_reg: rt, immediate: imm};
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic random_instr();
    logic [5:0] op;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4) op = 6'($urandom());
    else op = OPS[$urandom_range(16)];
    // small immediates keep loads and stores near written data
    if ($urandom_range(3) == 0) send(op, 5'($urandom()), 5'($urandom()), 16'($urandom()));
    else send(op, 5'($urandom_range(7)), 5'($urandom_range(7)),
              16'($signed($urandom_range(64)) - 32));
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, every operation, wrap, unaligned, register zero, bad opcodes
    send(mie_pkg::OP_ADDI, 5'd0, 5'd1, 16'h7FFF);
    send(mie_pkg::OP_ADDI, 5'd0, 5'd2, 16'h8000);
    send(mie_pkg::OP_ADDIU, 5'd2, 5'd3, 16'hFFFF);
    send(mie_pkg::OP_LUI, 5'd0, 5'd4, 16'hFFFF);
    send(mie_pkg::OP_ORI, 5'd4, 5'd4, 16'h8081);
    send(mie_pkg::OP_NORI, 5'd0, 5'd5, 16'h0000);
    send(mie_pkg::OP_ANDI, 5'd5, 5'd6, 16'hA5A5);
    send(mie_pkg::OP_SLTI, 5'd2, 5'd7, 16'h0001);
    send(mie_pkg::OP_SLTI, 5'd1, 5'd7, 16'h8000);
    send(mie_pkg::OP_ADDI, 5'd1, 5'd0, 16'h1234);
    send(mie_pkg::OP_SW, 5'd0, 5'd4, 16'hFFFF);
    send(mie_pkg::OP_SH, 5'd0, 5'd4, 16'h03FF);
    send(mie_pkg::OP_SB, 5'd1, 5'd5, 16'h0001);
    send(mie_pkg::OP_LW, 5'd0, 5'd8, 16'hFFFE);
    send(mie_pkg::OP_LH, 5'd0, 5'd9, 16'h03FF);
    send(mie_pkg::OP_LHU, 5'd0, 5'd10, 16'h03FF);
    send(mie_pkg::OP_LB, 5'd0, 5'd11, 16'hFFFF);
    send(mie_pkg::OP_LBU, 5'd0, 5'd12, 16'hFFFF);
    send(mie_pkg::OP_LW, 5'd0, 5'd0, 16'h0001);
    send(mie_pkg::OP_BEQ, 5'd0, 5'd0, 16'h8000);
    send(mie_pkg::OP_BNE, 5'd4, 5'd0, 16'h7FFF);
    send(mie_pkg::OP_BNE, 5'd0, 5'd0, 16'h0010);
    send(6'h3F, 5'd31, 5'd31, 16'hFFFF);
    send(6'h00, 5'd0, 5'd0, 16'h0000);
    // random part; the first 200 beats run without any idling
    quiet = 1'b1;
    for (int n = 0; n < 600; n++) begin
      if (n == 200) quiet = 1'b0;
      if (n == 250) hold_go = 1'b1;
      if (n == 350) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      random_instr();
    end
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

>>> mips_itype_execute_unit.f
rtl/mie_pkg.sv
rtl/mie_if.sv
rtl/mie_front.sv
rtl/mie_back.sv
rtl/mips_itype_execute_unit.sv
sim/mips_itype_execute_unit_checker.sv
sim/mips_itype_execute_unit_test.sv
